// ===== rtl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants for the tilt compensated heading block
// Fixed-point formats, transfer payload types, arctangent table, Q30 multiply.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int PRE_SHIFT    = 46 - SAMPLE_WIDTH;
    // vector datapath, angle, sine/cosine and multiplier operand widths
    localparam int VW = 52;
    localparam int AW = 34;
    localparam int CW = 33;
    localparam int MW = 48;
    localparam int TABLE_LEN = 24;

    localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 33'sd652032874;

    localparam logic [15:0] TARGET_RESET = 16'd17500;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [15:0]             t_centideg;

    typedef struct packed {
        t_sample accel_x;
        t_sample accel_y;
        t_sample accel_z;
        t_sample mag_x;
        t_sample mag_y;
        t_sample mag_z;
    } t_in_item;

    typedef struct packed {
        t_centideg heading_now;
        t_centideg turn_error;
    } t_out_item;

    // truncated Q30 arctangent of 2^-idx
    function automatic logic signed [AW-1:0] atan_q30(input int unsigned idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = 34'sh03243F6A8;
            1:       v = 34'sh01DAC6705;
            2:       v = 34'sh00FADBAFC;
            3:       v = 34'sh007F56EA6;
            4:       v = 34'sh003FEAB76;
            5:       v = 34'sh001FFD55B;
            6:       v = 34'sh000FFFAAA;
            7:       v = 34'sh0007FFF55;
            8:       v = 34'sh0003FFFEA;
            9:       v = 34'sh0001FFFFD;
            10:      v = 34'sh0000FFFFF;
            11:      v = 34'sh00007FFFF;
            12:      v = 34'sh00003FFFF;
            13:      v = 34'sh00001FFFF;
            14:      v = 34'sh00000FFFF;
            15:      v = 34'sh000007FFF;
            16:      v = 34'sh000003FFF;
            17:      v = 34'sh000001FFF;
            18:      v = 34'sh000000FFF;
            19:      v = 34'sh0000007FF;
            20:      v = 34'sh0000003FF;
            21:      v = 34'sh0000001FF;
            22:      v = 34'sh0000000FF;
            23:      v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor(floor(a / 2^15) * b / 2^15)
    function automatic logic signed [MW-1:0] mul_q30(input logic signed [MW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [MW-16:0]       a_sh;
        logic signed [MW-15+CW-1:0]  p;
        a_sh = $signed(a[MW-1:15]);
        p    = a_sh * b;
        return p[MW+14:15];
    endfunction

endpackage

// ===== rtl/thc_vector.sv =====
// ----------------------------------------------------------------------------
// thc_vector: pipelined CORDIC in vectoring mode
// Gives atan2(y, x) in Q30 radians and the gained magnitude, one stage a step.
// ----------------------------------------------------------------------------
module thc_vector
    import thc_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic signed [AW-1:0] o_z,
    output logic signed [VW-1:0] o_mag,
    output logic [SIDE_W-1:0]    o_side
);

    logic                 r_v    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic signed [VW-1:0] r_x    [0:STAGES];
    logic signed [VW-1:0] r_y    [0:STAGES];
    logic signed [AW-1:0] r_z    [0:STAGES];
    logic [SIDE_W-1:0]    r_side [0:STAGES];

    logic signed [VW-1:0] n_x0, n_y0;
    logic signed [AW-1:0] n_z0;

    // fold the left half-plane onto the right one
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [VW-1:0] n_x, n_y;
        logic signed [AW-1:0] n_z;

        always_comb begin
            if (r_y[k] >= 0) begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + atan_q30(k);
            end else begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_mag   = r_zero[STAGES] ? '0 : r_x[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ===== rtl/thc_rotate.sv =====
// ----------------------------------------------------------------------------
// thc_rotate: pipelined CORDIC in rotation mode
// Gives Q30 cosine and sine of a Q30 angle, gain folded into the start vector.
// ----------------------------------------------------------------------------
module thc_rotate
    import thc_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_z,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_cos,
    output logic signed [CW-1:0] o_sin,
    output logic [SIDE_W-1:0]    o_side
);

    logic                 r_v    [0:STAGES];
    logic                 r_neg  [0:STAGES];
    logic signed [CW-1:0] r_x    [0:STAGES];
    logic signed [CW-1:0] r_y    [0:STAGES];
    logic signed [AW-1:0] r_z    [0:STAGES];
    logic [SIDE_W-1:0]    r_side [0:STAGES];

    logic                 r_out_v;
    logic signed [CW-1:0] r_cos, r_sin;
    logic [SIDE_W-1:0]    r_out_side;

    logic signed [AW-1:0] n_z0;
    logic                 n_neg0;

    // bring the angle into the right half-plane, flip the result later
    always_comb begin
        n_z0   = i_z;
        n_neg0 = 1'b0;
        if (i_z > HALF_PI_Q30) begin
            n_z0   = i_z - PI_Q30;
            n_neg0 = 1'b1;
        end else if (i_z < -HALF_PI_Q30) begin
            n_z0   = i_z + PI_Q30;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0]  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v[0]  <= i_valid;
            r_out_v <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]     <= GAIN_Q30;
            r_y[0]     <= '0;
            r_z[0]     <= n_z0;
            r_neg[0]   <= n_neg0;
            r_side[0]  <= i_side;
            r_cos      <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_sin      <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
            r_out_side <= r_side[STAGES];
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CW-1:0] n_x, n_y;
        logic signed [AW-1:0] n_z;

        always_comb begin
            if (r_z[k] >= 0) begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - atan_q30(k);
            end else begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_side  = r_out_side;

endmodule

// ===== rtl/thc_deg.sv =====
// ----------------------------------------------------------------------------
// thc_deg: angle to hundredths of a degree and wrapped turn error
// Divides by pi through a reciprocal estimate with a two-step correction.
// ----------------------------------------------------------------------------
module thc_deg
    import thc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_z,
    input  t_centideg            i_target,
    output logic                 o_valid,
    output t_out_item            o_item
);

    // floor(18000 * 2^48 / pi_q30), an under-estimate of the reciprocal
    localparam logic [63:0] RECIP64 = (64'd18000 << 48) / 64'd3373259426;
    localparam logic [30:0] RECIP   = RECIP64[30:0];
    localparam logic [46:0] HALF_PI = 47'd1686629713;
    localparam logic [46:0] PI_U    = 47'd3373259426;
    localparam logic [46:0] TWO_PI  = 47'd6746518852;
    localparam logic [15:0] LIMIT   = 16'd18000;

    logic [4:0]  r_v;
    logic        r_neg0, r_neg1, r_neg2;
    logic [31:0] r_abs;
    logic [14:0] r_q0, r_q0b;
    logic [46:0] r_num, r_num2, r_qpi;
    t_centideg   r_h, r_h_out, r_err;

    logic signed [AW-1:0] n_abs;
    logic [62:0]          n_est;
    logic [46:0]          n_num, n_rem;
    logic [15:0]          n_q, n_qc;
    logic signed [16:0]   n_e;

    always_comb begin
        n_abs = (i_z < 0) ? -i_z : i_z;
        n_est = 63'(r_abs) * 63'(RECIP);
        n_num = 47'(r_abs) * 47'd18000 + HALF_PI;
        n_rem = r_num2 - r_qpi;
        n_q   = 16'(r_q0b);
        if (n_rem >= TWO_PI) begin
            n_q = 16'(r_q0b) + 16'd2;
        end else if (n_rem >= PI_U) begin
            n_q = 16'(r_q0b) + 16'd1;
        end
        n_qc = (n_q > LIMIT) ? LIMIT : n_q;
        // wrap target minus heading into one half turn either way
        n_e = 17'(i_target) - 17'(r_h);
        if (n_e > 17'sd18000) begin
            n_e = n_e - 17'sd36000;
        end else if (n_e < -17'sd18000) begin
            n_e = n_e + 17'sd36000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs   <= n_abs[31:0];
            r_neg0  <= i_z < 0;
            r_q0    <= n_est[62:48];
            r_num   <= n_num;
            r_neg1  <= r_neg0;
            r_q0b   <= r_q0;
            r_qpi   <= 47'(r_q0) * PI_U;
            r_num2  <= r_num;
            r_neg2  <= r_neg1;
            r_h     <= r_neg2 ? -$signed(n_qc) : $signed(n_qc);
            r_h_out <= r_h;
            r_err   <= n_e[15:0];
        end
    end

    assign o_valid            = r_v[4];
    assign o_item.heading_now = r_h_out;
    assign o_item.turn_error  = r_err;

endmodule

// ===== rtl/tilt_compensated_heading_error.sv =====
// ----------------------------------------------------------------------------
// tilt_compensated_heading_error: tilt compensated compass heading and turn error
// Path to result valid: input register, roll and pitch vectoring CORDICs, the
// rotation CORDICs side by side, tilt multiply, heading CORDIC, degree conversion.
// Throughput: one sample set per cycle; the whole pipeline holds on output stall.
// Reset: synchronous, active low; clears all valid bits, target returns to 175.00.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_error
    import thc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int SIDE3 = 3 * VW;

    // whole pipeline advances together unless the finished result is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // target register: saturate then shift into the signed half-turn range
    t_centideg   r_target;
    logic [15:0] n_tsat;
    t_centideg   n_target;

    always_comb begin
        n_tsat   = (i_cfg_wr_data > 16'd36000) ? 16'd36000 : i_cfg_wr_data;
        n_target = (n_tsat > 16'd18000) ? $signed(n_tsat - 16'd36000) : $signed(n_tsat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= $signed(TARGET_RESET);
        end else if (i_cfg_wr_en) begin
            r_target <= n_target;
        end
    end

    // input stage: scale raw counts into the wide fixed-point frame
    function automatic logic signed [VW-1:0] scale(input t_sample s);
        logic signed [VW-1:0] w;
        w = VW'(s);
        return w <<< PRE_SHIFT;
    endfunction

    logic                 r_in_v;
    logic signed [VW-1:0] r_ax, r_ay, r_az, r_mx, r_my, r_mz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= scale(i_in_data.accel_x);
            r_ay <= scale(i_in_data.accel_y);
            r_az <= scale(i_in_data.accel_z);
            r_mx <= scale(i_in_data.mag_x);
            r_my <= scale(i_in_data.mag_y);
            r_mz <= scale(i_in_data.mag_z);
        end
    end

    // roll = atan2(ay, az); carry ax and the magnetic vector alongside
    logic                 roll_v;
    logic signed [AW-1:0] roll_z;
    logic signed [VW-1:0] roll_mag;
    logic [4*VW-1:0]      roll_side;

    thc_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(4 * VW)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_x     (r_az),
        .i_y     (r_ay),
        .i_side  ({r_ax, r_mx, r_my, r_mz}),
        .o_valid (roll_v),
        .o_z     (roll_z),
        .o_mag   (roll_mag),
        .o_side  (roll_side)
    );

    // remove the CORDIC gain from the roll magnitude: sqrt(ay^2 + az^2)
    logic signed [VW-17:0] mag_sh;
    logic signed [VW+14:0] n_rprod;
    logic                  r_r_v;
    logic signed [VW-1:0]  r_r, r_nax;
    logic signed [AW-1:0]  r_roll;
    logic [SIDE3-1:0]      r_mvec;

    assign mag_sh  = roll_mag[VW-1:16];
    assign n_rprod = mag_sh * $signed({1'b0, GAIN_Q30[29:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (en) begin
            r_r_v <= roll_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r    <= n_rprod[VW+13:14];
            r_nax  <= -$signed(roll_side[4*VW-1:3*VW]);
            r_roll <= roll_z;
            r_mvec <= roll_side[SIDE3-1:0];
        end
    end

    // pitch = atan2(-ax, r)
    logic                 pitch_v;
    logic signed [AW-1:0] pitch_z;
    logic [AW+SIDE3-1:0]  pitch_side;

    thc_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(AW + SIDE3)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_r_v),
        .i_x     (r_r),
        .i_y     (r_nax),
        .i_side  ({r_roll, r_mvec}),
        .o_valid (pitch_v),
        .o_z     (pitch_z),
        .o_mag   (),
        .o_side  (pitch_side)
    );

    // sine and cosine of roll and pitch side by side
    logic                 rot_v;
    logic signed [CW-1:0] cr, sr, cp, sp;
    logic [SIDE3-1:0]     rot_side;

    thc_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE3)) u_rot_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_z     ($signed(pitch_side[AW+SIDE3-1:SIDE3])),
        .i_side  (pitch_side[SIDE3-1:0]),
        .o_valid (rot_v),
        .o_cos   (cr),
        .o_sin   (sr),
        .o_side  (rot_side)
    );

    thc_rotate #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_rot_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_z     (pitch_z),
        .i_side  (1'b0),
        .o_valid (),
        .o_cos   (cp),
        .o_sin   (sp),
        .o_side  ()
    );

    // tilt compensation: multiply levels in their own stages, then a stage that sums Xh and Yh
    logic signed [MW-1:0] mx_m, my_m, mz_m;
    assign mx_m = MW'($signed(rot_side[3*VW-1:2*VW]));
    assign my_m = MW'($signed(rot_side[2*VW-1:VW]));
    assign mz_m = MW'($signed(rot_side[VW-1:0]));

    logic                 r_m1_v, r_m2_v, r_m3_v;
    logic signed [MW-1:0] r_p1, r_p2a, r_p3a, r_p4, r_p5;
    logic signed [CW-1:0] r_sp;
    logic signed [MW-1:0] r_q1, r_q2, r_q3, r_q4, r_q5;
    logic signed [VW-1:0] r_xh, r_yh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= rot_v;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1  <= mul_q30(mx_m, cp);
            r_p2a <= mul_q30(my_m, sr);
            r_p3a <= mul_q30(mz_m, cr);
            r_p4  <= mul_q30(my_m, cr);
            r_p5  <= mul_q30(mz_m, sr);
            r_sp  <= sp;
            r_q1  <= r_p1;
            r_q2  <= mul_q30(r_p2a, r_sp);
            r_q3  <= mul_q30(r_p3a, r_sp);
            r_q4  <= r_p4;
            r_q5  <= r_p5;
            r_xh  <= VW'(r_q1) + VW'(r_q2) + VW'(r_q3);
            r_yh  <= VW'(r_q4) - VW'(r_q5);
        end
    end

    // heading = atan2(Yh, Xh)
    logic                 head_v;
    logic signed [AW-1:0] head_z;

    thc_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_v),
        .i_x     (r_xh),
        .i_y     (r_yh),
        .i_side  (1'b0),
        .o_valid (head_v),
        .o_z     (head_z),
        .o_mag   (),
        .o_side  ()
    );

    // convert to hundredths of a degree; last register is the output register
    thc_deg u_deg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (head_v),
        .i_z      (head_z),
        .i_target (r_target),
        .o_valid  (o_out_valid),
        .o_item   (o_out_data)
    );

endmodule
